[src/mst_pkg.sv]
`timescale 1ns / 1ps
package mst_pkg;
   localparam int MAX_EDGES    = 64;
   localparam int MAX_VERTICES = 32;
   localparam int EIDX_W       = $clog2(MAX_EDGES);
   localparam int ECNT_W       = $clog2(MAX_EDGES + 1);
   localparam int VMAP_SIZE    = 64;
   localparam int VCNT_W       = $clog2(MAX_VERTICES + 1) + 1;
   localparam int EDGE_W       = 28;

   localparam logic [1:0] ST_TREE         = 2'd0;
   localparam logic [1:0] ST_DISCONNECTED = 2'd1;
   localparam logic [1:0] ST_OVERFLOW     = 2'd2;

   typedef struct packed {
      logic [5:0]         endpoint_a;
      logic [5:0]         endpoint_b;
      logic signed [15:0] edge_weight;
      logic               last_edge;
   } req_type;

   typedef struct packed {
      logic [5:0]         tree_a;
      logic [5:0]         tree_b;
      logic signed [15:0] tree_weight;
      logic [1:0]         status;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic [5:0]         a;
      logic [5:0]         b;
      logic signed [15:0] w;
   } edge_type;
endpackage

[src/min_spanning_tree_sorted_edges_unit.sv]
`timescale 1ns / 1ps
// Minimum spanning tree unit. Edges load one beat per cycle while busy is low;
// the beat with last_edge set starts the compute and busy stays high until the
// final result. Sort is an exchange sort on an edge memory with one read and
// one write port: each (i,j) pair is read in S_RDI and S_RDJ and compared in
// S_CMP, a swap adds S_SWP, and each row ends back in S_RDI. Seeding in S_SEED
// reads entry 0 and marks it chosen. The tree pass rescans the sorted memory
// from the start for every chosen edge, plus a final scan, then an emit scan
// and a pass through S_DONE back to load. The chosen mark of each edge is kept
// in the edge memory next to the edge. A graph that overflowed reports its
// status the cycle after its last beat and busy stays low. Results appear on
// rsp_* for exactly one cycle with rsp_valid; the receiver cannot stall.
module min_spanning_tree_sorted_edges_unit
   import mst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   input  logic    csr_we,
   input  logic [5:0] csr_wdata,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   typedef enum logic [8:0] {
      S_LOAD  = 9'b000000001,
      S_RDI   = 9'b000000010,
      S_RDJ   = 9'b000000100,
      S_CMP   = 9'b000001000,
      S_SWP   = 9'b000010000,
      S_SEED  = 9'b000100000,
      S_SCAN  = 9'b001000000,
      S_EMIT  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [5:0] vcount_ff;
   logic [ECNT_W-1:0] total_ff, total_in;
   logic ovf_ff, ovf_in;
   logic [ECNT_W-1:0] i_ff, i_in, j_ff, j_in;
   edge_type ei_ff, ei_in;
   logic [VMAP_SIZE-1:0] map_ff, map_in;
   logic [VCNT_W-1:0] count_ff, count_in;
   logic pend_ff, pend_in;
   logic rv_ff, rv_in;
   rsp_type rd_ff, rd_in;

   logic we, wm;
   logic [EIDX_W-1:0] wa, ra;
   edge_type wd, rdat;
   logic rmark;
   logic [EDGE_W:0] rraw;

   // memory word: chosen mark on top of the edge
   mst_ram #(.WIDTH(EDGE_W + 1), .DEPTH(MAX_EDGES)) u_store (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data({wm, wd}),
      .rd_addr(ra), .rd_data(rraw));
   assign rdat = edge_type'(rraw[EDGE_W-1:0]);
   assign rmark = rraw[EDGE_W];

   logic [VCNT_W-1:0] n_eff;
   assign n_eff = (vcount_ff > 6'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                : VCNT_W'(vcount_ff);

   assign busy = (state_ff != S_LOAD);
   assign rsp_valid = rv_ff;
   assign rsp_data = rd_ff;

   always_comb begin
      state_in = state_ff; total_in = total_ff; ovf_in = ovf_ff;
      i_in = i_ff; j_in = j_ff; ei_in = ei_ff; map_in = map_ff;
      count_in = count_ff;
      pend_in = 1'b0; rv_in = 1'b0; rd_in = rd_ff;
      we = 1'b0; wm = 1'b0; wa = i_ff[EIDX_W-1:0]; wd = ei_ff; ra = i_ff[EIDX_W-1:0];
      case (state_ff)
         S_LOAD: begin
            if (start) begin
               // loaded edges start with a clear chosen mark
               wa = total_ff[EIDX_W-1:0];
               wd = '{req_data.endpoint_a, req_data.endpoint_b, req_data.edge_weight};
               if (total_ff < ECNT_W'(MAX_EDGES)) begin
                  we = 1'b1;
                  total_in = total_ff + 1'b1;
               end else ovf_in = 1'b1;
               if (req_data.last_edge) begin
                  if (ovf_in) begin
                     rv_in = 1'b1;
                     rd_in = '{6'd0, 6'd0, 16'sd0, ST_OVERFLOW, 1'b1};
                     total_in = '0; ovf_in = 1'b0;
                  end else begin
                     i_in = '0; j_in = ECNT_W'(1);
                     state_in = S_RDI;
                  end
               end
            end
         end
         S_RDI: begin
            // read entry i (data valid next cycle)
            if (j_ff >= total_ff) begin
               i_in = i_ff + 1'b1; j_in = i_ff + 2'd2;
               if (i_ff + 2'd2 >= total_ff) begin
                  i_in = '0; state_in = S_SEED;
               end
            end else begin
               ra = i_ff[EIDX_W-1:0];
               state_in = S_RDJ;
            end
         end
         S_RDJ: begin
            ei_in = rdat;
            ra = j_ff[EIDX_W-1:0];
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ei_ff.w > rdat.w) begin
               we = 1'b1; wa = i_ff[EIDX_W-1:0]; wd = rdat;
               state_in = S_SWP;
            end else begin
               j_in = j_ff + 1'b1; state_in = S_RDI;
            end
         end
         S_SWP: begin
            we = 1'b1; wa = j_ff[EIDX_W-1:0]; wd = ei_ff;
            j_in = j_ff + 1'b1; state_in = S_RDI;
         end
         S_SEED: begin
            // entry 0 is the read address; pend marks valid read data
            pend_in = 1'b1; ra = '0;
            if (pend_ff) begin
               map_in = '0;
               map_in[rdat.a] = 1'b1; map_in[rdat.b] = 1'b1;
               // seed edge is chosen
               we = 1'b1; wm = 1'b1; wa = '0; wd = rdat;
               count_in = VCNT_W'(1);
               i_in = '0; pend_in = 1'b0; state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ra = i_ff[EIDX_W-1:0];
            pend_in = 1'b1; i_in = i_ff + 1'b1;
            if (pend_ff) begin
               // data is for entry i_ff-1
               if (map_ff[rdat.a] != map_ff[rdat.b]) begin
                  map_in[rdat.a] = 1'b1; map_in[rdat.b] = 1'b1;
                  we = 1'b1; wm = 1'b1; wa = EIDX_W'(i_ff - 1'b1); wd = rdat;
                  count_in = count_ff + 1'b1;
                  i_in = '0; pend_in = 1'b0;
               end else if (i_ff >= total_ff) begin
                  pend_in = 1'b0; i_in = '0;
                  if (count_ff != n_eff - 1'b1) begin
                     rv_in = 1'b1;
                     rd_in = '{6'd0, 6'd0, 16'sd0, ST_DISCONNECTED, 1'b1};
                     state_in = S_DONE;
                  end else begin
                     count_in = '0; state_in = S_EMIT;
                  end
               end
            end else if (i_ff >= total_ff) begin
               pend_in = 1'b0;
            end
         end
         S_EMIT: begin
            ra = i_ff[EIDX_W-1:0];
            pend_in = (i_ff < total_ff);
            i_in = i_ff + 1'b1;
            if (pend_ff && rmark) begin
               count_in = count_ff + 1'b1;
               rv_in = 1'b1;
               rd_in = '{rdat.a, rdat.b, rdat.w, ST_TREE,
                         (count_ff + 1'b1 == n_eff - 1'b1)};
            end
            if (!pend_ff && i_ff > total_ff) state_in = S_DONE;
         end
         S_DONE: begin
            total_in = '0; ovf_in = 1'b0; state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; vcount_ff <= 6'd32; total_ff <= '0;
         ovf_ff <= 1'b0; rv_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; total_ff <= total_in; ovf_ff <= ovf_in;
         rv_ff <= rv_in; pend_ff <= pend_in;
         if (csr_we) vcount_ff <= csr_wdata;
      end
      i_ff <= i_in; j_ff <= j_in; ei_ff <= ei_in; map_ff <= map_in;
      count_ff <= count_in;
      rd_ff <= rd_in;
   end

   // status results always close the graph
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_TREE |-> rsp_data.last_result)
      else $error("status result not marked last");
   a_no_overflow_total: assert property (@(posedge clock) disable iff (reset)
      total_ff <= ECNT_W'(MAX_EDGES))
      else $error("edge count beyond store");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_LOAD) |-> total_ff == '0 && !ovf_ff)
      else $error("graph state not cleared");
endmodule

[src/mst_ram.sv]
`timescale 1ns / 1ps
module mst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[sim/min_spanning_tree_sorted_edges_unit_test.sv]
`timescale 1ns / 1ps
module min_spanning_tree_sorted_edges_unit_test;
   import mst_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    csr_we;
   logic [5:0] csr_wdata;
   logic    rsp_valid;
   rsp_type rsp_data;

   min_spanning_tree_sorted_edges_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // a directed row is either a register write or one edge beat
   typedef struct {
      bit         is_cfg;
      logic [5:0] cfg_value;
      req_type    edge_beat;
      bit         typed;
      rsp_type    want;
   } script_row_type;

   // predictor state: the graph being collected and the vertex count
   edge_type   graph_edges[$];
   bit         graph_overflow;
   logic [5:0] vertex_cfg;
   rsp_type    tree_expect[$];
   int         mismatches;
   int         cycles;
   int         beats_sent;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // sort, grow the tree from the lightest edge, then emit or report disconnected
   function automatic void predict_tree();
      edge_type   e[$];
      edge_type   t;
      bit         picked[$];
      bit [63:0]  in_tree;
      int         m, cnt, n, k;
      bit         grew, ia, ib;
      rsp_type    r;
      e = graph_edges;
      m = e.size();
      for (int i = 0; i + 1 < m; i++)
         for (int j = i + 1; j < m; j++)
            if (e[i].w > e[j].w) begin
               t = e[i];
               e[i] = e[j];
               e[j] = t;
            end
      for (int i = 0; i < m; i++) picked.push_back(1'b0);
      in_tree = '0;
      picked[0] = 1'b1;
      in_tree[e[0].a] = 1'b1;
      in_tree[e[0].b] = 1'b1;
      cnt = 1;
      grew = 1'b1;
      while (grew) begin
         grew = 1'b0;
         for (int i = 0; i < m; i++) begin
            ia = in_tree[e[i].a];
            ib = in_tree[e[i].b];
            if (ia != ib) begin
               cnt++;
               picked[i] = 1'b1;
               in_tree[e[i].a] = 1'b1;
               in_tree[e[i].b] = 1'b1;
               grew = 1'b1;
               break;
            end
         end
      end
      n = (vertex_cfg > MAX_VERTICES) ? MAX_VERTICES : vertex_cfg;
      if (cnt != n - 1) begin
         r = '{tree_a: '0, tree_b: '0, tree_weight: '0, status: ST_DISCONNECTED,
               last_result: 1'b1};
         tree_expect.push_back(r);
      end else begin
         k = 0;
         for (int i = 0; i < m; i++)
            if (picked[i]) begin
               k++;
               r = '{tree_a: e[i].a, tree_b: e[i].b, tree_weight: e[i].w,
                     status: ST_TREE, last_result: (k == cnt)};
               tree_expect.push_back(r);
            end
      end
   endfunction

   // bookkeeping for one accepted edge beat
   task automatic record_beat(req_type it, bit typed, rsp_type want);
      edge_type ed;
      rsp_type  r;
      beats_sent++;
      if (graph_edges.size() < MAX_EDGES) begin
         ed = '{a: it.endpoint_a, b: it.endpoint_b, w: it.edge_weight};
         graph_edges.push_back(ed);
      end else begin
         graph_overflow = 1'b1;
      end
      if (it.last_edge) begin
         if (typed) begin
            tree_expect.push_back(want);
         end else if (graph_overflow) begin
            r = '{tree_a: '0, tree_b: '0, tree_weight: '0, status: ST_OVERFLOW,
                  last_result: 1'b1};
            tree_expect.push_back(r);
         end else begin
            predict_tree();
         end
         graph_edges.delete();
         graph_overflow = 1'b0;
      end
   endtask

   // one beat: random gap, then hold start until busy is low at an edge
   task automatic send_beat(req_type it, bit typed, rsp_type want);
      int  gap;
      bit  taken;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= it;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
         @(negedge clock);
      end
      record_beat(it, typed, want);
   endtask

   // drain every expected result and let the block settle
   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (tree_expect.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_vertex_count(logic [5:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      vertex_cfg = value;
   endtask

   // random graph: well formed (spanning tree plus extras), noisy, or oversized
   task automatic send_graph(int kind);
      req_type  beats[$];
      req_type  it;
      req_type  t;
      rsp_type  none;
      int       n, extra, m, j;
      bit       narrow;
      none = '0;
      narrow = ($urandom_range(0, 2) == 0);
      n = (vertex_cfg > MAX_VERTICES) ? MAX_VERTICES : vertex_cfg;
      if (kind == 0 && n >= 2) begin
         for (int v = 2; v <= n; v++) begin
            it.endpoint_a = 6'(v);
            it.endpoint_b = 6'($urandom_range(1, v - 1));
            if ($urandom_range(0, 1)) begin
               it.endpoint_a = it.endpoint_b;
               it.endpoint_b = 6'(v);
            end
            it.edge_weight = 16'(narrow ? $urandom_range(0, 3) : $urandom_range(0, 65535));
            it.last_edge = 1'b0;
            beats.push_back(it);
         end
         extra = $urandom_range(0, 4);
         for (int x = 0; x < extra; x++) begin
            it.endpoint_a = 6'($urandom_range(1, n));
            it.endpoint_b = 6'($urandom_range(1, n));
            it.edge_weight = 16'(narrow ? $urandom_range(0, 3) : $urandom_range(0, 65535));
            it.last_edge = 1'b0;
            beats.push_back(it);
         end
         for (int x = beats.size() - 1; x > 0; x--) begin
            j = $urandom_range(0, x);
            t = beats[x];
            beats[x] = beats[j];
            beats[j] = t;
         end
      end else begin
         m = (kind == 2) ? $urandom_range(MAX_EDGES + 1, MAX_EDGES + 6)
                         : $urandom_range(1, 10);
         for (int x = 0; x < m; x++) begin
            it.endpoint_a = 6'($urandom_range(0, 63));
            it.endpoint_b = 6'($urandom_range(0, 63));
            it.edge_weight = 16'(narrow ? $urandom_range(0, 3) : $urandom_range(0, 65535));
            it.last_edge = 1'b0;
            beats.push_back(it);
         end
      end
      beats[beats.size() - 1].last_edge = 1'b1;
      foreach (beats[x]) send_beat(beats[x], 1'b0, none);
   endtask

   // result checker: each strobe against the oldest expectation
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid) begin
         if (tree_expect.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            mismatches++;
         end else begin
            w = tree_expect.pop_front();
            if (rsp_data.tree_a !== w.tree_a) begin
               $display("%0t: tree_a expected %0d actual %0d", $time, w.tree_a, rsp_data.tree_a);
               mismatches++;
            end
            if (rsp_data.tree_b !== w.tree_b) begin
               $display("%0t: tree_b expected %0d actual %0d", $time, w.tree_b, rsp_data.tree_b);
               mismatches++;
            end
            if (rsp_data.tree_weight !== w.tree_weight) begin
               $display("%0t: tree_weight expected %0d actual %0d", $time,
                        w.tree_weight, rsp_data.tree_weight);
               mismatches++;
            end
            if (rsp_data.status !== w.status) begin
               $display("%0t: status expected %0d actual %0d", $time, w.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.last_result !== w.last_result) begin
               $display("%0t: last_result expected %0d actual %0d", $time,
                        w.last_result, rsp_data.last_result);
               mismatches++;
            end
         end
      end
   end

   initial begin
      script_row_type script[$];
      script_row_type row;
      rsp_type   none;
      int        kind, guard;
      logic [5:0] vc_pick;
      none = '0;
      cycles = 0;
      mismatches = 0;
      beats_sent = 0;
      graph_overflow = 1'b0;
      vertex_cfg = 6'd32;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;

      // after reset: one edge cannot span 32 vertices
      script.push_back('{0, 0, '{6'd1, 6'd2, 16'sd5, 1'b1}, 1,
                         '{6'd0, 6'd0, 16'sd0, ST_DISCONNECTED, 1'b1}});
      script.push_back('{1, 6'd2, '0, 0, none});
      // two vertices, most negative weight
      script.push_back('{0, 0, '{6'd1, 6'd2, -16'sd32768, 1'b1}, 1,
                         '{6'd1, 6'd2, -16'sd32768, ST_TREE, 1'b1}});
      // self-loop seed still counts as a tree edge
      script.push_back('{0, 0, '{6'd5, 6'd5, 16'sd7, 1'b1}, 1,
                         '{6'd5, 6'd5, 16'sd7, ST_TREE, 1'b1}});
      // out-of-range endpoints act as extra vertices
      script.push_back('{0, 0, '{6'd0, 6'd63, 16'sd32767, 1'b1}, 1,
                         '{6'd0, 6'd63, 16'sd32767, ST_TREE, 1'b1}});
      script.push_back('{1, 6'd3, '0, 0, none});
      script.push_back('{0, 0, '{6'd1, 6'd2, 16'sd32767, 1'b0}, 0, none});
      script.push_back('{0, 0, '{6'd2, 6'd3, -16'sd1, 1'b0}, 0, none});
      script.push_back('{0, 0, '{6'd1, 6'd3, 16'sd0, 1'b1}, 0, none});
      script.push_back('{0, 0, '{6'd3, 6'd1, 16'sd4, 1'b0}, 0, none});
      script.push_back('{0, 0, '{6'd2, 6'd1, 16'sd4, 1'b0}, 0, none});
      script.push_back('{0, 0, '{6'd3, 6'd2, 16'sd4, 1'b1}, 0, none});
      // vertex count of one or zero is always disconnected
      script.push_back('{1, 6'd1, '0, 0, none});
      script.push_back('{0, 0, '{6'd1, 6'd1, 16'sd0, 1'b1}, 1,
                         '{6'd0, 6'd0, 16'sd0, ST_DISCONNECTED, 1'b1}});
      script.push_back('{1, 6'd0, '0, 0, none});
      script.push_back('{0, 0, '{6'd1, 6'd2, 16'sd1, 1'b1}, 1,
                         '{6'd0, 6'd0, 16'sd0, ST_DISCONNECTED, 1'b1}});
      // count above the maximum is limited to 32
      script.push_back('{1, 6'd63, '0, 0, none});
      script.push_back('{0, 0, '{6'd1, 6'd2, 16'sd1, 1'b1}, 1,
                         '{6'd0, 6'd0, 16'sd0, ST_DISCONNECTED, 1'b1}});
      script.push_back('{1, 6'd4, '0, 0, none});
      script.push_back('{0, 0, '{6'd4, 6'd3, 16'sd9, 1'b0}, 0, none});
      script.push_back('{0, 0, '{6'd2, 6'd4, 16'sd9, 1'b0}, 0, none});
      script.push_back('{0, 0, '{6'd0, 6'd1, -16'sd3, 1'b0}, 0, none});
      script.push_back('{0, 0, '{6'd1, 6'd2, 16'sd2, 1'b1}, 0, none});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[x]) begin
         row = script[x];
         if (row.is_cfg) write_vertex_count(row.cfg_value);
         else send_beat(row.edge_beat, row.typed, row.want);
      end

      // random graphs; register changes between phases
      guard = 0;
      while (beats_sent < 130) begin
         guard++;
         if (guard % 4 == 1) begin
            case ($urandom_range(0, 7))
               0: vc_pick = 6'd0;
               1: vc_pick = 6'd1;
               2: vc_pick = 6'd32;
               3: vc_pick = 6'd63;
               default: vc_pick = 6'($urandom_range(2, 8));
            endcase
            write_vertex_count(vc_pick);
         end
         kind = $urandom_range(0, 9);
         if (kind < 7) kind = 0;
         else if (kind < 9) kind = 1;
         else kind = (guard % 5 == 0) ? 2 : 1;
         send_graph(kind);
         // sender holds off until everything has drained
         if (guard % 7 == 0) wait_idle();
      end
      if (beats_sent < 300) send_graph(2);

      start <= 1'b0;
      @(negedge clock);
      while (tree_expect.size() != 0 || busy) @(negedge clock);
      repeat (50) @(negedge clock);
      if (mismatches == 0 && tree_expect.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

[files.f]
src/mst_pkg.sv
src/mst_ram.sv
src/min_spanning_tree_sorted_edges_unit.sv
sim/min_spanning_tree_sorted_edges_unit_test.sv
